// ===== sv/lsp_pkg.sv =====
// Shared types, constants and weight-table generator for the Loop subdivision point block.
`timescale 1ns / 1ps

package lsp_pkg;

    // Point rule codes
    typedef enum logic [1:0] {
        MODE_VERTEX   = 2'd0,
        MODE_INT_EDGE = 2'd1,
        MODE_BND_EDGE = 2'd2,
        MODE_NONE     = 2'd3
    } t_mode;

    localparam int POS_W  = 32;
    localparam int RING_W = 36;
    localparam int OPP_W  = 33;
    localparam int OUT_W  = 32;
    localparam int LANES  = 3;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // Per-stage advance strobes handed to each lane
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

    // Restoring long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Vertex weight alpha for valence n in Q(w), elaboration only
    function automatic logic [63:0] alpha_q(input int unsigned n, input int unsigned w);
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] c4u;
        logic [63:0] sq;
        logic [63:0] a30;
        longint      cosv;
        longint      c4;
        longint      diff;
        if (n <= 3) begin
            return 64'd3 << (w - 4);
        end
        theta = udiv64(64'd2 * PI_Q30, 64'(n));
        t2    = (theta * theta) >> 30;
        term  = ONE_Q30;
        cosv  = longint'(ONE_Q30);
        for (int k = 1; k <= 10; k++) begin
            term = udiv64((term * t2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) == 1) begin
                cosv = cosv - longint'(term);
            end else begin
                cosv = cosv + longint'(term);
            end
        end
        c4 = (longint'(3) <<< 29) + cosv;
        if (c4 < 0) begin
            c4 = 0;
        end
        c4u  = 64'(c4);
        sq   = (c4u * c4u) >> 34;
        diff = (longint'(5) <<< 27) - longint'(sq);
        if (diff < 0) begin
            diff = 0;
        end
        a30 = udiv64(64'(diff), 64'(n));
        return (a30 + (64'd1 << (29 - w))) >> (30 - w);
    endfunction

endpackage

// ===== sv/lsp_weight_rom.sv =====
// Constant weight table: alpha and old-point weight indexed by clamped valence.
`timescale 1ns / 1ps

module lsp_weight_rom #(
    parameter int MAX_VALENCE      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic [4:0]                  i_valence,
    output logic [WEIGHT_FRAC_BITS-1:0] o_alpha,
    output logic [WEIGHT_FRAC_BITS:0]   o_wold
);

    localparam int AW    = WEIGHT_FRAC_BITS;
    localparam int IDX_W = $clog2(MAX_VALENCE + 1);
    localparam int CW    = (IDX_W > 5) ? IDX_W : 5;

    logic [AW-1:0]    tbl_alpha [0:MAX_VALENCE];
    logic [AW:0]      tbl_wold  [0:MAX_VALENCE];
    logic [CW-1:0]    val_ext;
    logic [IDX_W-1:0] idx;

    for (genvar g = 0; g <= MAX_VALENCE; g++) begin : g_ent
        localparam logic [63:0] A_G  = lsp_pkg::alpha_q(g, WEIGHT_FRAC_BITS);
        localparam logic [63:0] WO_G = (64'd1 << WEIGHT_FRAC_BITS) - 64'(g) * A_G;
        assign tbl_alpha[g] = A_G[AW-1:0];
        assign tbl_wold[g]  = WO_G[AW:0];
    end

    // valence above the table depth uses the last entry
    always_comb begin
        val_ext = CW'(i_valence);
        if (val_ext > CW'(MAX_VALENCE)) begin
            idx = IDX_W'(MAX_VALENCE);
        end else begin
            idx = val_ext[IDX_W-1:0];
        end
    end

    assign o_alpha = tbl_alpha[idx];
    assign o_wold  = tbl_wold[idx];

endmodule

// ===== sv/lsp_lane.sv =====
// One coordinate lane: weighting, rounding and saturation over three stages.
`timescale 1ns / 1ps

module lsp_lane #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  lsp_pkg::t_stage_en                  i_en,
    input  lsp_pkg::t_mode                      i_mode,
    input  logic [WEIGHT_FRAC_BITS-1:0]         i_alpha,
    input  logic [WEIGHT_FRAC_BITS:0]           i_wold,
    input  logic signed [lsp_pkg::POS_W-1:0]    i_pos,
    input  logic signed [lsp_pkg::RING_W-1:0]   i_ring,
    input  logic signed [lsp_pkg::OPP_W-1:0]    i_opp,
    output logic signed [lsp_pkg::OUT_W-1:0]    o_res,
    output logic                                o_sat
);

    localparam int AW  = WEIGHT_FRAC_BITS;
    localparam int SW  = WEIGHT_FRAC_BITS + 39;
    localparam int PPW = AW + 2 + lsp_pkg::POS_W;
    localparam int PRW = AW + 1 + lsp_pkg::RING_W;

    localparam logic signed [SW-1:0] SAT_MAX = SW'(lsp_pkg::OUT_MAX);
    localparam logic signed [SW-1:0] SAT_MIN = SW'(lsp_pkg::OUT_MIN);

    logic signed [PPW-1:0] prod_p;
    logic signed [PRW-1:0] prod_r;
    logic signed [SW-1:0]  ring_ext;
    logic signed [SW-1:0]  opp_ext;
    logic signed [SW-1:0]  half;
    logic signed [SW-1:0]  shifted;

    lsp_pkg::t_mode        r_mode2;
    lsp_pkg::t_mode        r_mode3;
    logic signed [SW-1:0]  r_pa2;
    logic signed [SW-1:0]  r_pb2;
    logic signed [SW-1:0]  r_sum3;
    logic signed [lsp_pkg::OUT_W-1:0] r_res4;
    logic                  r_sat4;

    assign prod_p   = $signed({1'b0, i_wold}) * i_pos;
    assign prod_r   = $signed({1'b0, i_alpha}) * i_ring;
    assign ring_ext = SW'(i_ring);
    assign opp_ext  = SW'(i_opp);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_mode2 <= i_mode;
            unique case (i_mode)
                lsp_pkg::MODE_VERTEX: begin
                    r_pa2 <= SW'(prod_p);
                    r_pb2 <= SW'(prod_r);
                end
                lsp_pkg::MODE_INT_EDGE: begin
                    r_pa2 <= (ring_ext <<< 1) + ring_ext + opp_ext;
                    r_pb2 <= '0;
                end
                lsp_pkg::MODE_BND_EDGE: begin
                    r_pa2 <= ring_ext;
                    r_pb2 <= '0;
                end
                default: begin
                    r_pa2 <= '0;
                    r_pb2 <= '0;
                end
            endcase
        end
    end

    // round half up: add half an LSB of the target scale
    always_comb begin
        unique case (r_mode2)
            lsp_pkg::MODE_VERTEX:   half = SW'(1) <<< (WEIGHT_FRAC_BITS - 1);
            lsp_pkg::MODE_INT_EDGE: half = SW'(4);
            lsp_pkg::MODE_BND_EDGE: half = SW'(1);
            default:                half = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_mode3 <= r_mode2;
            r_sum3  <= r_pa2 + r_pb2 + half;
        end
    end

    always_comb begin
        unique case (r_mode3)
            lsp_pkg::MODE_VERTEX:   shifted = r_sum3 >>> WEIGHT_FRAC_BITS;
            lsp_pkg::MODE_INT_EDGE: shifted = r_sum3 >>> 3;
            lsp_pkg::MODE_BND_EDGE: shifted = r_sum3 >>> 1;
            default:                shifted = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            if (shifted > SAT_MAX) begin
                r_res4 <= lsp_pkg::OUT_MAX;
                r_sat4 <= 1'b1;
            end else if (shifted < SAT_MIN) begin
                r_res4 <= lsp_pkg::OUT_MIN;
                r_sat4 <= 1'b1;
            end else begin
                r_res4 <= shifted[lsp_pkg::OUT_W-1:0];
                r_sat4 <= 1'b0;
            end
        end
    end

    assign o_res = r_res4;
    assign o_sat = r_sat4;

endmodule

// ===== sv/loop_subdivision_point_rules.sv =====
// Top level of the Loop subdivision point block: input register, weight table, three lanes, merge.
// An accepted request passes from the input register through S2, S3 and S4 to the output register.
// Throughput: one request per cycle while the output is not stalled; the five-stage pipeline closes bubbles on its own.
// A stalled output keeps the pipeline filling until every stage holds a request.
// Reset (i_rst_n low, synchronous) empties every stage; no clearing pass is needed.
`timescale 1ns / 1ps

module loop_subdivision_point_rules #(
    parameter int MAX_VALENCE      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_mode,
    input  logic [4:0]                        i_valence,
    input  logic signed [lsp_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [lsp_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [lsp_pkg::POS_W-1:0]  i_pos_z,
    input  logic signed [lsp_pkg::RING_W-1:0] i_ring_sum_x,
    input  logic signed [lsp_pkg::RING_W-1:0] i_ring_sum_y,
    input  logic signed [lsp_pkg::RING_W-1:0] i_ring_sum_z,
    input  logic signed [lsp_pkg::OPP_W-1:0]  i_opposite_sum_x,
    input  logic signed [lsp_pkg::OPP_W-1:0]  i_opposite_sum_y,
    input  logic signed [lsp_pkg::OPP_W-1:0]  i_opposite_sum_z,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [lsp_pkg::OUT_W-1:0]  o_out_x,
    output logic signed [lsp_pkg::OUT_W-1:0]  o_out_y,
    output logic signed [lsp_pkg::OUT_W-1:0]  o_out_z,
    output logic                              o_saturated
);

    localparam int AW = WEIGHT_FRAC_BITS;

    // Pipeline:
    //   S1  input register, weight table lookup registered alongside
    //   S2  products (vertex) or 3*ring+opp / ring (edges), per lane
    //   S3  sum plus rounding half
    //   S4  scale shift and clamp, per lane
    //   OUT merge: lanes gathered, saturation flags ORed

    logic r_v1, r_v2, r_v3, r_v4, r_vout;
    logic en1, en2, en3, en4, en_out;
    logic accept;

    lsp_pkg::t_stage_en lane_en;

    logic [AW-1:0] rom_alpha;
    logic [AW:0]   rom_wold;

    lsp_pkg::t_mode r_mode1;
    logic [AW-1:0]  r_alpha1;
    logic [AW:0]    r_wold1;

    logic signed [lsp_pkg::POS_W-1:0]  pos_in  [lsp_pkg::LANES];
    logic signed [lsp_pkg::RING_W-1:0] ring_in [lsp_pkg::LANES];
    logic signed [lsp_pkg::OPP_W-1:0]  opp_in  [lsp_pkg::LANES];
    logic signed [lsp_pkg::POS_W-1:0]  r_pos1  [lsp_pkg::LANES];
    logic signed [lsp_pkg::RING_W-1:0] r_ring1 [lsp_pkg::LANES];
    logic signed [lsp_pkg::OPP_W-1:0]  r_opp1  [lsp_pkg::LANES];
    logic signed [lsp_pkg::OUT_W-1:0]  lane_res [lsp_pkg::LANES];
    logic                              lane_sat [lsp_pkg::LANES];

    logic signed [lsp_pkg::OUT_W-1:0]  r_out_x, r_out_y, r_out_z;
    logic                              r_sat;

    assign pos_in[0]  = i_pos_x;
    assign pos_in[1]  = i_pos_y;
    assign pos_in[2]  = i_pos_z;
    assign ring_in[0] = i_ring_sum_x;
    assign ring_in[1] = i_ring_sum_y;
    assign ring_in[2] = i_ring_sum_z;
    assign opp_in[0]  = i_opposite_sum_x;
    assign opp_in[1]  = i_opposite_sum_y;
    assign opp_in[2]  = i_opposite_sum_z;

    // Each stage moves when it is empty or the stage after it moves; the
    // output register frees up as soon as the consumer takes its result.
    assign en_out = !r_vout || !i_stall;
    assign en4    = !r_v4 || en_out;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign o_stall = !en1;
    assign accept  = i_valid && en1;

    assign lane_en.s2 = en2;
    assign lane_en.s3 = en3;
    assign lane_en.s4 = en4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_vout <= 1'b0;
        end else begin
            if (en1)    r_v1   <= accept;
            if (en2)    r_v2   <= r_v1;
            if (en3)    r_v3   <= r_v2;
            if (en4)    r_v4   <= r_v3;
            if (en_out) r_vout <= r_v4;
        end
    end

    lsp_weight_rom #(
        .MAX_VALENCE      (MAX_VALENCE),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_rom (
        .i_valence (i_valence),
        .o_alpha   (rom_alpha),
        .o_wold    (rom_wold)
    );

    // S1: request payload and its weights
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_mode1  <= lsp_pkg::t_mode'(i_mode);
            r_alpha1 <= rom_alpha;
            r_wold1  <= rom_wold;
            for (int l = 0; l < lsp_pkg::LANES; l++) begin
                r_pos1[l]  <= pos_in[l];
                r_ring1[l] <= ring_in[l];
                r_opp1[l]  <= opp_in[l];
            end
        end
    end

    // S2..S4: one lane per coordinate
    for (genvar l = 0; l < lsp_pkg::LANES; l++) begin : g_lane
        lsp_lane #(
            .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (lane_en),
            .i_mode  (r_mode1),
            .i_alpha (r_alpha1),
            .i_wold  (r_wold1),
            .i_pos   (r_pos1[l]),
            .i_ring  (r_ring1[l]),
            .i_opp   (r_opp1[l]),
            .o_res   (lane_res[l]),
            .o_sat   (lane_sat[l])
        );
    end

    // Merge: gather the lanes and OR their clamp flags
    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_x <= lane_res[0];
            r_out_y <= lane_res[1];
            r_out_z <= lane_res[2];
            r_sat   <= lane_sat[0] | lane_sat[1] | lane_sat[2];
        end
    end

    assign o_valid     = r_vout;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_saturated = r_sat;

endmodule

// ===== sv/lsp_checker.sv =====
// Port-level checker for the Loop subdivision point block, bound to the top level.
`timescale 1ns / 1ps

module lsp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [lsp_pkg::OUT_W-1:0]  o_out_x,
    input logic signed [lsp_pkg::OUT_W-1:0]  o_out_y,
    input logic signed [lsp_pkg::OUT_W-1:0]  o_out_z,
    input logic                              o_saturated
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a consumer that does not stall never blocks new requests
    a_no_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("request stalled while output drains freely");

    // an empty output stage always takes the next request
    a_idle_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("request stalled with no result pending");

    // a clamp flag means some coordinate sits at a range limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_out_x == lsp_pkg::OUT_MAX || o_out_x == lsp_pkg::OUT_MIN ||
             o_out_y == lsp_pkg::OUT_MAX || o_out_y == lsp_pkg::OUT_MIN ||
             o_out_z == lsp_pkg::OUT_MAX || o_out_z == lsp_pkg::OUT_MIN))
        else $error("saturation flag without a clamped coordinate");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z)
             && $stable(o_saturated)))
        else $error("stalled result changed");

endmodule

bind loop_subdivision_point_rules lsp_checker u_lsp_checker (.*);
